@@ src/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// jse_pkg: shared types and constants for the json string escape encoder
// command segment layout, character codes, hex and base64 digit lookup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jse_pkg;

    // command entries between the front and the back
    localparam int SEG_BYTES   = 6;
    localparam int SEG_COUNT   = 3;
    localparam int QUEUE_DEPTH = 4;

    // characters that show up in the encoded text
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UP_B   = 8'h42;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // control bytes with a short escape
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_HT = 8'h09;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_CR = 8'h0D;

    // replacement character U+FFFD
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    typedef logic [7:0] byte_t;

    // one run of output bytes, bytes[0] goes out first
    typedef struct packed {
        logic [2:0]                 len;
        logic [SEG_BYTES-1:0][7:0]  bytes;
    } seg_t;

    // prefix, body and tail of one request's output
    typedef struct packed {
        seg_t [SEG_COUNT-1:0] seg;
    } cmd_t;

    function automatic byte_t hex_digit(input logic [3:0] v);
        byte_t r;
        if (v < 4'd10) begin
            r = CH_ZERO + {4'd0, v};
        end else begin
            r = 8'h57 + {4'd0, v};
        end
        return r;
    endfunction

    function automatic byte_t b64_digit(input logic [5:0] v);
        byte_t r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'd0, v};
        end else if (v < 6'd52) begin
            r = 8'h47 + {2'd0, v};
        end else if (v < 6'd62) begin
            r = 8'h30 - 8'd52 + {2'd0, v};
        end else if (v == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage

@@ src/jse_front.sv @@
// ----------------------------------------------------------------------------
// jse_front: request classifier
// tracks string mode, utf-8 validation and base64 grouping, and turns each
// request into a command of up to three byte segments
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_accept,
    input  logic [7:0]    data_byte,
    input  logic          first_of_string,
    input  logic          last_of_string,
    input  logic          binary_mode,
    input  logic          empty_string,
    output jse_pkg::cmd_t cmd,
    output logic          cmd_push
);
    import jse_pkg::*;

    // validator states: number of continuation bytes still due and their range
    localparam logic [2:0] VS_ACCEPT = 3'd0;
    localparam logic [2:0] VS_NEED1  = 3'd1;
    localparam logic [2:0] VS_NEED2  = 3'd2;
    localparam logic [2:0] VS_E0     = 3'd3;
    localparam logic [2:0] VS_ED     = 3'd4;
    localparam logic [2:0] VS_NEED3  = 3'd5;
    localparam logic [2:0] VS_F0     = 3'd6;
    localparam logic [2:0] VS_F4     = 3'd7;

    logic             mode_binary_reg, mode_binary_next;
    logic [2:0][7:0]  seq_bytes_reg, seq_bytes_next;
    logic [1:0]       seq_count_reg, seq_count_next;
    logic [2:0]       vstate_reg, vstate_next;
    logic [1:0][7:0]  b64_carry_reg, b64_carry_next;
    logic [1:0]       b64_count_reg, b64_count_next;

    logic       eff_mode;
    logic [2:0] eff_vs;
    logic [1:0] eff_sc;
    logic [1:0] eff_bc;
    logic [7:0] cont_lo, cont_hi;
    logic [2:0] cont_next;

    function automatic seg_t esc_seg(input byte_t ch);
        seg_t s;
        s = '0;
        if (ch >= 8'h20 && ch != CH_BSLASH && ch != CH_QUOTE) begin
            s.len      = 3'd1;
            s.bytes[0] = ch;
        end else begin
            s.len      = 3'd2;
            s.bytes[0] = CH_BSLASH;
            case (ch)
                CH_QUOTE:  s.bytes[1] = CH_QUOTE;
                CH_BSLASH: s.bytes[1] = CH_BSLASH;
                CTL_BS:    s.bytes[1] = CH_LO_B;
                CTL_FF:    s.bytes[1] = CH_LO_F;
                CTL_LF:    s.bytes[1] = CH_LO_N;
                CTL_CR:    s.bytes[1] = CH_LO_R;
                CTL_HT:    s.bytes[1] = CH_LO_T;
                default: begin
                    s.len      = 3'd6;
                    s.bytes[1] = CH_LO_U;
                    s.bytes[2] = CH_ZERO;
                    s.bytes[3] = CH_ZERO;
                    s.bytes[4] = hex_digit(ch[7:4]);
                    s.bytes[5] = hex_digit(ch[3:0]);
                end
            endcase
        end
        return s;
    endfunction

    function automatic seg_t repl_seg();
        seg_t s;
        s = '0;
        s.len      = 3'd3;
        s.bytes[0] = REPL_B0;
        s.bytes[1] = REPL_B1;
        s.bytes[2] = REPL_B2;
        return s;
    endfunction

    // pending state as seen by this request; a new string drops it
    assign eff_mode = first_of_string ? binary_mode : mode_binary_reg;
    assign eff_vs   = first_of_string ? VS_ACCEPT : vstate_reg;
    assign eff_sc   = first_of_string ? 2'd0 : seq_count_reg;
    assign eff_bc   = first_of_string ? 2'd0 : b64_count_reg;

    // allowed range of the next continuation byte
    always_comb begin
        cont_lo   = 8'h80;
        cont_hi   = 8'hBF;
        cont_next = VS_ACCEPT;
        unique case (eff_vs)
            VS_NEED1: cont_next = VS_ACCEPT;
            VS_NEED2: cont_next = VS_NEED1;
            VS_E0: begin
                cont_lo   = 8'hA0;
                cont_next = VS_NEED1;
            end
            VS_ED: begin
                cont_hi   = 8'h9F;
                cont_next = VS_NEED1;
            end
            VS_NEED3: cont_next = VS_NEED2;
            VS_F0: begin
                cont_lo   = 8'h90;
                cont_next = VS_NEED2;
            end
            VS_F4: begin
                cont_hi   = 8'h8F;
                cont_next = VS_NEED2;
            end
            default: cont_next = VS_ACCEPT;
        endcase
    end

    always_comb begin
        mode_binary_next = mode_binary_reg;
        seq_bytes_next   = seq_bytes_reg;
        seq_count_next   = eff_sc;
        vstate_next      = eff_vs;
        b64_carry_next   = b64_carry_reg;
        b64_count_next   = eff_bc;
        cmd              = '0;

        if (empty_string) begin
            seq_count_next    = 2'd0;
            vstate_next       = VS_ACCEPT;
            b64_count_next    = 2'd0;
            cmd.seg[0].len      = 3'd2;
            cmd.seg[0].bytes[0] = CH_QUOTE;
            cmd.seg[0].bytes[1] = CH_QUOTE;
        end else begin
            if (first_of_string) begin
                mode_binary_next = binary_mode;
                if (binary_mode) begin
                    cmd.seg[0].len      = 3'd6;
                    cmd.seg[0].bytes[0] = CH_LBRACK;
                    cmd.seg[0].bytes[1] = CH_QUOTE;
                    cmd.seg[0].bytes[2] = CH_UP_B;
                    cmd.seg[0].bytes[3] = CH_QUOTE;
                    cmd.seg[0].bytes[4] = CH_COMMA;
                    cmd.seg[0].bytes[5] = CH_QUOTE;
                end else begin
                    cmd.seg[0].len      = 3'd1;
                    cmd.seg[0].bytes[0] = CH_QUOTE;
                end
            end

            if (eff_mode) begin
                // base64: three bytes make four digits
                if (eff_bc != 2'd2) begin
                    b64_carry_next[eff_bc[0]] = data_byte;
                    b64_count_next            = eff_bc + 2'd1;
                end else begin
                    cmd.seg[1].len      = 3'd4;
                    cmd.seg[1].bytes[0] = b64_digit(b64_carry_reg[0][7:2]);
                    cmd.seg[1].bytes[1] = b64_digit({b64_carry_reg[0][1:0],
                                                     b64_carry_reg[1][7:4]});
                    cmd.seg[1].bytes[2] = b64_digit({b64_carry_reg[1][3:0],
                                                     data_byte[7:6]});
                    cmd.seg[1].bytes[3] = b64_digit(data_byte[5:0]);
                    b64_count_next      = 2'd0;
                end
                if (last_of_string) begin
                    if (b64_count_next == 2'd0) begin
                        cmd.seg[2].len      = 3'd2;
                        cmd.seg[2].bytes[0] = CH_QUOTE;
                        cmd.seg[2].bytes[1] = CH_RBRACK;
                    end else begin
                        cmd.seg[2].len      = 3'd6;
                        cmd.seg[2].bytes[0] = b64_digit(b64_carry_next[0][7:2]);
                        cmd.seg[2].bytes[3] = CH_EQUAL;
                        cmd.seg[2].bytes[4] = CH_QUOTE;
                        cmd.seg[2].bytes[5] = CH_RBRACK;
                        if (b64_count_next == 2'd1) begin
                            cmd.seg[2].bytes[1] = b64_digit({b64_carry_next[0][1:0], 4'd0});
                            cmd.seg[2].bytes[2] = CH_EQUAL;
                        end else begin
                            cmd.seg[2].bytes[1] = b64_digit({b64_carry_next[0][1:0],
                                                             b64_carry_next[1][7:4]});
                            cmd.seg[2].bytes[2] = b64_digit({b64_carry_next[1][3:0], 2'd0});
                        end
                    end
                    b64_count_next = 2'd0;
                end
            end else begin
                if (eff_vs == VS_ACCEPT) begin
                    // lead byte or plain ascii
                    seq_bytes_next[0] = data_byte;
                    seq_count_next    = 2'd1;
                    if (data_byte < 8'h80) begin
                        cmd.seg[1]     = esc_seg(data_byte);
                        seq_count_next = 2'd0;
                    end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
                        vstate_next = VS_NEED1;
                    end else if (data_byte == 8'hE0) begin
                        vstate_next = VS_E0;
                    end else if (data_byte == 8'hED) begin
                        vstate_next = VS_ED;
                    end else if (data_byte >= 8'hE1 && data_byte <= 8'hEF) begin
                        vstate_next = VS_NEED2;
                    end else if (data_byte == 8'hF0) begin
                        vstate_next = VS_F0;
                    end else if (data_byte >= 8'hF1 && data_byte <= 8'hF3) begin
                        vstate_next = VS_NEED3;
                    end else if (data_byte == 8'hF4) begin
                        vstate_next = VS_F4;
                    end else begin
                        cmd.seg[1]     = repl_seg();
                        seq_count_next = 2'd0;
                    end
                end else if (data_byte < cont_lo || data_byte > cont_hi) begin
                    // bad continuation: whole held sequence and this byte go
                    cmd.seg[1]     = repl_seg();
                    seq_count_next = 2'd0;
                    vstate_next    = VS_ACCEPT;
                end else if (cont_next == VS_ACCEPT) begin
                    // sequence complete: held bytes then this one
                    cmd.seg[1].len = {1'b0, eff_sc} + 3'd1;
                    for (int i = 0; i < 3; i++) begin
                        cmd.seg[1].bytes[i] = (2'(i) < eff_sc) ? seq_bytes_reg[i]
                                                                : data_byte;
                    end
                    cmd.seg[1].bytes[3] = data_byte;
                    seq_count_next      = 2'd0;
                    vstate_next         = VS_ACCEPT;
                end else begin
                    if (eff_sc != 2'd3) begin
                        seq_bytes_next[eff_sc] = data_byte;
                        seq_count_next         = eff_sc + 2'd1;
                    end
                    vstate_next = cont_next;
                end
                if (last_of_string) begin
                    if (seq_count_next != 2'd0 || vstate_next != VS_ACCEPT) begin
                        cmd.seg[2]          = repl_seg();
                        cmd.seg[2].len      = 3'd4;
                        cmd.seg[2].bytes[3] = CH_QUOTE;
                    end else begin
                        cmd.seg[2].len      = 3'd1;
                        cmd.seg[2].bytes[0] = CH_QUOTE;
                    end
                    seq_count_next = 2'd0;
                    vstate_next    = VS_ACCEPT;
                end
            end
        end
    end

    assign cmd_push = in_accept &&
                      (cmd.seg[0].len != 3'd0 || cmd.seg[1].len != 3'd0 ||
                       cmd.seg[2].len != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_binary_reg <= 1'b0;
            seq_count_reg   <= 2'd0;
            vstate_reg      <= VS_ACCEPT;
            b64_count_reg   <= 2'd0;
        end else if (in_accept) begin
            mode_binary_reg <= mode_binary_next;
            seq_count_reg   <= seq_count_next;
            vstate_reg      <= vstate_next;
            b64_count_reg   <= b64_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            seq_bytes_reg <= seq_bytes_next;
            b64_carry_reg <= b64_carry_next;
        end
    end

endmodule

@@ src/jse_queue.sv @@
// ----------------------------------------------------------------------------
// jse_queue: command queue between front and back
// small register file queue, one push unless full and one pop per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_queue #(
    parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  jse_pkg::cmd_t push_cmd,
    input  logic          pop,
    output jse_pkg::cmd_t head_cmd,
    output logic          q_valid,
    output logic          q_full
);
    import jse_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign q_full   = (count_reg == CW'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_cmd = mem[rd_ptr_reg];
    assign do_push  = push && !q_full;
    assign do_pop   = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/jse_back.sv @@
// ----------------------------------------------------------------------------
// jse_back: byte serializer
// walks the segments of the head command and sends one byte per cycle while m_ is not
// stalled, through a registered output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  jse_pkg::cmd_t head_cmd,
    input  logic          q_valid,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast
);
    import jse_pkg::*;

    logic [1:0] si_reg, si_next;
    logic [2:0] bi_reg, bi_next;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;

    logic       has0, has1;
    logic [1:0] cur;
    logic [2:0] cur_len;
    logic       seg_end, more, done, load;
    byte_t      cur_byte;

    // first non-empty segment at or after the saved segment index
    assign has0    = (head_cmd.seg[0].len != 3'd0) && (si_reg == 2'd0);
    assign has1    = (head_cmd.seg[1].len != 3'd0) && (si_reg <= 2'd1);
    assign cur     = has0 ? 2'd0 : (has1 ? 2'd1 : 2'd2);
    assign cur_len = head_cmd.seg[cur].len;
    assign cur_byte = head_cmd.seg[cur].bytes[bi_reg];
    assign seg_end = (bi_reg == cur_len - 3'd1);

    always_comb begin
        unique case (cur)
            2'd0:    more = (head_cmd.seg[1].len != 3'd0) || (head_cmd.seg[2].len != 3'd0);
            2'd1:    more = (head_cmd.seg[2].len != 3'd0);
            default: more = 1'b0;
        endcase
    end

    assign done = seg_end && !more;
    assign load = q_valid && (!m_tvalid_reg || m_tready);
    assign pop  = load && done;

    always_comb begin
        si_next = si_reg;
        bi_next = bi_reg;
        if (load) begin
            if (done) begin
                si_next = 2'd0;
                bi_next = 3'd0;
            end else if (seg_end) begin
                si_next = cur + 2'd1;
                bi_next = 3'd0;
            end else begin
                si_next = cur;
                bi_next = bi_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            si_reg       <= 2'd0;
            bi_reg       <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            si_reg <= si_next;
            bi_reg <= bi_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= cur_byte;
            m_tlast_reg <= done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ src/json_string_escape_encoder.sv @@
// ----------------------------------------------------------------------------
// json_string_escape_encoder: byte stream to json string text
// escaped utf-8 text with replacement of bad sequences, or base64 array form
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one request per string byte. tdata[7:0] is the byte,
//   tdata[8] marks the first byte of a string, tlast marks the last one,
//   tuser[0] selects base64 form (sampled on the first byte), tuser[1]
//   marks an empty string, which sends "" and nothing else.
//   m_ channel: one encoded byte per transfer, tlast on the final byte
//   produced by a request. requests that only buffer bytes (utf-8 lead and
//   continuation bytes, base64 bytes short of a group) produce nothing.
//   output path: the request is written into the command queue, and its
//   first byte then goes through the output register onto m_.
//   throughput: the front takes one request per cycle while the command
//   queue has room; the back sends one byte per cycle while m_ is not
//   stalled, and a request produces 1 byte for plain text, up to 12.
//   the queue of QUEUE_DEPTH commands absorbs bursts of short requests.
//   reset: clears string mode, pending utf-8 and base64 state, the queue
//   and the output stage. a stalled m_ side holds its byte; s_tready drops
//   only when the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_escape_encoder #(
    parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] first_of_string, rest zero
    input  logic        s_tlast,   // last_of_string
    input  logic [1:0]  s_tuser,   // [0] binary_mode, [1] empty_string
    // encoded bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // last_of_run
);
    import jse_pkg::*;

    logic accept;
    cmd_t front_cmd;
    logic front_push;
    cmd_t head_cmd;
    logic q_valid;
    logic q_full;
    logic back_pop;

    // request taken whenever the queue has a free slot
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // classify the request and update string state
    jse_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (accept),
        .data_byte       (s_tdata[7:0]),
        .first_of_string (s_tdata[8]),
        .last_of_string  (s_tlast),
        .binary_mode     (s_tuser[0]),
        .empty_string    (s_tuser[1]),
        .cmd             (front_cmd),
        .cmd_push        (front_push)
    );

    // commands waiting for the serializer
    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (front_push),
        .push_cmd (front_cmd),
        .pop      (back_pop),
        .head_cmd (head_cmd),
        .q_valid  (q_valid),
        .q_full   (q_full)
    );

    // one byte per cycle onto the output while m_tready allows
    jse_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_valid  (q_valid),
        .pop      (back_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/jse_checker.sv @@
// ----------------------------------------------------------------------------
// jse_checker: port level checks for the encoder
// output hold under stall, reset behavior, input ready behavior
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // stalled output byte stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output byte dropped or changed while stalled");

    // reset empties the queue and the output stage
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset left output valid or input blocked");

    // the queue only fills through accepted requests
    a_ready_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && !s_tvalid |=> s_tready)
        else $error("input ready dropped with no request taken");

endmodule

bind json_string_escape_encoder jse_checker u_jse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ test/jse_stream_checker.sv @@
// ----------------------------------------------------------------------------
// jse_stream_checker: scoreboard for the json string escape encoder
// watches both stream channels, predicts the encoded bytes of every request
// and compares each encoded byte with the oldest byte still owed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] first_of_string
    input  logic        s_tlast,
    input  logic [1:0]  s_tuser,   // [0] binary_mode, [1] empty_string
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_byte
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          bytes_owed,
    output int          requests_seen,
    output int          bytes_checked,
    output int          repl_count
);
    import jse_pkg::*;

    // utf-8 validator: how many continuation bytes remain and their range
    typedef enum logic [3:0] {
        U_ACCEPT,
        U_NEED1,
        U_NEED2,
        U_NEED2_E0,
        U_NEED2_ED,
        U_NEED3,
        U_NEED3_F0,
        U_NEED3_F4
    } utf8_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } json_byte_t;

    logic        mode_b64;
    logic [7:0]  seq_buf [3];
    logic [1:0]  seq_cnt;
    utf8_state_t u_state;
    logic [7:0]  b64_hold [2];
    logic [1:0]  b64_cnt;

    byte_t       run_q [$];
    json_byte_t  json_bytes_q [$];
    json_byte_t  want;

    function automatic void queue_out(input byte_t b);
        run_q.push_back(b);
    endfunction

    function automatic void queue_repl();
        queue_out(REPL_B0);
        queue_out(REPL_B1);
        queue_out(REPL_B2);
        seq_cnt = 2'd0;
        u_state = U_ACCEPT;
        repl_count++;
    endfunction

    function automatic void drop_pending();
        seq_cnt = 2'd0;
        u_state = U_ACCEPT;
        b64_cnt = 2'd0;
    endfunction

    function automatic byte_t hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_ZERO + {4'd0, v};
        end
        return 8'h61 + {4'd0, v} - 8'd10;
    endfunction

    function automatic byte_t b64_char(input logic [5:0] v);
        if (v < 6'd26) return 8'h41 + {2'd0, v};
        if (v < 6'd52) return 8'h61 + {2'd0, v} - 8'd26;
        if (v < 6'd62) return 8'h30 + {2'd0, v} - 8'd52;
        if (v == 6'd62) return 8'h2B;
        return 8'h2F;
    endfunction

    function automatic void escape_ascii(input byte_t ch);
        if (ch >= 8'h20 && ch != CH_QUOTE && ch != CH_BSLASH) begin
            queue_out(ch);
            return;
        end
        queue_out(CH_BSLASH);
        case (ch)
            CH_QUOTE:  queue_out(CH_QUOTE);
            CH_BSLASH: queue_out(CH_BSLASH);
            CTL_BS:    queue_out(CH_LO_B);
            CTL_FF:    queue_out(CH_LO_F);
            CTL_LF:    queue_out(CH_LO_N);
            CTL_CR:    queue_out(CH_LO_R);
            CTL_HT:    queue_out(CH_LO_T);
            default: begin
                // other control bytes as \u00xx, lowercase hex
                queue_out(CH_LO_U);
                queue_out(CH_ZERO);
                queue_out(CH_ZERO);
                queue_out(hex_char(ch[7:4]));
                queue_out(hex_char(ch[3:0]));
            end
        endcase
    endfunction

    function automatic void text_byte(input byte_t ch);
        byte_t       lo;
        byte_t       hi;
        utf8_state_t nxt;
        lo  = 8'h80;
        hi  = 8'hBF;
        nxt = U_ACCEPT;
        if (u_state == U_ACCEPT) begin
            if (ch < 8'h80) begin
                escape_ascii(ch);
                return;
            end
            if (ch >= 8'hC2 && ch <= 8'hDF)      u_state = U_NEED1;
            else if (ch == 8'hE0)                u_state = U_NEED2_E0;
            else if (ch == 8'hED)                u_state = U_NEED2_ED;
            else if (ch >= 8'hE1 && ch <= 8'hEF) u_state = U_NEED2;
            else if (ch == 8'hF0)                u_state = U_NEED3_F0;
            else if (ch >= 8'hF1 && ch <= 8'hF3) u_state = U_NEED3;
            else if (ch == 8'hF4)                u_state = U_NEED3_F4;
            else begin
                queue_repl();
                return;
            end
            seq_buf[0] = ch;
            seq_cnt    = 2'd1;
            return;
        end
        // second byte ranges exclude overlongs, surrogates and beyond U+10FFFF
        case (u_state)
            U_NEED1:    nxt = U_ACCEPT;
            U_NEED2:    nxt = U_NEED1;
            U_NEED2_E0: begin lo = 8'hA0; nxt = U_NEED1; end
            U_NEED2_ED: begin hi = 8'h9F; nxt = U_NEED1; end
            U_NEED3:    nxt = U_NEED2;
            U_NEED3_F0: begin lo = 8'h90; nxt = U_NEED2; end
            U_NEED3_F4: begin hi = 8'h8F; nxt = U_NEED2; end
            default: begin
                queue_repl();
                return;
            end
        endcase
        if (ch < lo || ch > hi) begin
            // failing byte is swallowed together with the held ones
            queue_repl();
            return;
        end
        if (nxt == U_ACCEPT) begin
            for (int i = 0; i < seq_cnt; i++) queue_out(seq_buf[i]);
            queue_out(ch);
            seq_cnt = 2'd0;
            u_state = U_ACCEPT;
            return;
        end
        seq_buf[seq_cnt] = ch;
        seq_cnt++;
        u_state = nxt;
    endfunction

    function automatic void binary_byte(input byte_t ch);
        byte_t a;
        byte_t b;
        if (b64_cnt < 2'd2) begin
            b64_hold[b64_cnt[0]] = ch;
            b64_cnt++;
            return;
        end
        a = b64_hold[0];
        b = b64_hold[1];
        queue_out(b64_char(a[7:2]));
        queue_out(b64_char({a[1:0], b[7:4]}));
        queue_out(b64_char({b[3:0], ch[7:6]}));
        queue_out(b64_char(ch[5:0]));
        b64_cnt = 2'd0;
    endfunction

    function automatic void binary_flush();
        byte_t a;
        byte_t b;
        a = b64_hold[0];
        b = b64_hold[1];
        if (b64_cnt == 2'd1) begin
            queue_out(b64_char(a[7:2]));
            queue_out(b64_char({a[1:0], 4'd0}));
            queue_out(CH_EQUAL);
            queue_out(CH_EQUAL);
        end else if (b64_cnt == 2'd2) begin
            queue_out(b64_char(a[7:2]));
            queue_out(b64_char({a[1:0], b[7:4]}));
            queue_out(b64_char({b[3:0], 2'd0}));
            queue_out(CH_EQUAL);
        end
        b64_cnt = 2'd0;
    endfunction

    // works out the encoded bytes of one request and appends them to the owed list
    function automatic void encode_request(input byte_t ch, input logic first,
                                           input logic last, input logic bin,
                                           input logic empty);
        json_byte_t e;
        run_q.delete();
        if (empty) begin
            drop_pending();
            queue_out(CH_QUOTE);
            queue_out(CH_QUOTE);
        end else begin
            if (first) begin
                drop_pending();
                mode_b64 = bin;
                if (bin) begin
                    queue_out(CH_LBRACK);
                    queue_out(CH_QUOTE);
                    queue_out(CH_UP_B);
                    queue_out(CH_QUOTE);
                    queue_out(CH_COMMA);
                    queue_out(CH_QUOTE);
                end else begin
                    queue_out(CH_QUOTE);
                end
            end
            if (mode_b64) begin
                binary_byte(ch);
                if (last) begin
                    binary_flush();
                    queue_out(CH_QUOTE);
                    queue_out(CH_RBRACK);
                end
            end else begin
                text_byte(ch);
                if (last) begin
                    if (seq_cnt != 2'd0 || u_state != U_ACCEPT) queue_repl();
                    queue_out(CH_QUOTE);
                end
            end
        end
        for (int i = 0; i < run_q.size(); i++) begin
            e.data = run_q[i];
            e.last = (i == run_q.size() - 1);
            json_bytes_q.push_back(e);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        mismatch_count++;
        $display("%0t ns mismatch: %s got %h want %h", $time, what, got, exp_val);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_b64       = 1'b0;
            seq_buf[0]     = 8'd0;
            seq_buf[1]     = 8'd0;
            seq_buf[2]     = 8'd0;
            b64_hold[0]    = 8'd0;
            b64_hold[1]    = 8'd0;
            drop_pending();
            json_bytes_q.delete();
            mismatch_count = 0;
            requests_seen  = 0;
            bytes_checked  = 0;
            repl_count     = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                requests_seen++;
                encode_request(s_tdata[7:0], s_tdata[8], s_tlast, s_tuser[0], s_tuser[1]);
            end
            if (m_tvalid && m_tready) begin
                bytes_checked++;
                if (json_bytes_q.size() == 0) begin
                    report_mismatch("byte with nothing owed", m_tdata, 8'd0);
                end else begin
                    want = json_bytes_q.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch("out_byte", m_tdata, want.data);
                    if (m_tlast !== want.last)
                        report_mismatch("last_of_run", {7'd0, m_tlast}, {7'd0, want.last});
                end
            end
        end
        bytes_owed <= json_bytes_q.size();
    end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: top level for the json string escape encoder
// drives directed and random strings in text and base64 form through the
// request channel with bursty timing, stalls the encoded byte channel on
// changing patterns, and takes the verdict from the stream checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import jse_pkg::*;

    localparam int RANDOM_ITEMS = 96;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer on either side
    localparam int TAIL_CYCLES  = 24;    // idle tail after the final drain, leave plenty

    // receiver stall patterns
    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_RHYTHM
    } rx_pattern_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] data_byte, [8] first_of_string, rest zero
    logic        s_tlast;   // last_of_string
    logic [1:0]  s_tuser;   // [0] binary_mode, [1] empty_string
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic        m_tlast;   // last_of_run

    int mismatch_count;
    int bytes_owed;
    int requests_seen;
    int bytes_checked;
    int repl_count;

    int burst_left  = 0;
    int idle_cycles = 0;
    int n_text      = 0;
    int n_b64       = 0;
    int n_empty     = 0;
    int n_random    = 0;

    rx_pattern_t rx_mode   = RX_FREE;
    int          rx_left   = 0;
    int          rx_tick   = 0;

    byte_t str_q [$];

    always #10 aclk = ~aclk;

    json_string_escape_encoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    jse_stream_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .bytes_owed     (bytes_owed),
        .requests_seen  (requests_seen),
        .bytes_checked  (bytes_checked),
        .repl_count     (repl_count)
    );

    // receiver: switch between stall patterns at random intervals
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_pattern_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(40, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_FREE:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_tready <= (rx_tick % 4 == 0);
            default:   m_tready <= (rx_tick % 3 != 0);
        endcase
    end

    // watchdog: give up when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("stalled for %0d cycles with %0d bytes owed", idle_cycles, bytes_owed);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one request, sent in bursts with random gaps; returns at the accepting edge
    task automatic send_byte(input byte_t data, input logic first, input logic last,
                             input logic bin, input logic empty);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // now and then a long stretch back to back
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(20, 40);
            end else begin
                burst_left = $urandom_range(1, 8);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, first, data};
        s_tlast  <= last;
        s_tuser  <= {empty, bin};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold off the sender until every owed byte has come out
    task automatic drain_outputs();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (bytes_owed != 0) @(posedge aclk);
    endtask

    // sends str_q as one string, optionally left open without a last byte
    task automatic send_string(input logic bin, input logic keep_open);
        int n;
        n = str_q.size();
        for (int i = 0; i < n; i++)
            send_byte(str_q[i], i == 0, (i == n - 1) && !keep_open, bin, 1'b0);
    endtask

    // random text: mostly well formed utf-8, with escapes and broken sequences mixed in
    task automatic build_text();
        int          n_chars;
        int          roll;
        logic [20:0] cp;
        byte_t       b;
        str_q.delete();
        n_chars = $urandom_range(1, 6);
        repeat (n_chars) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                str_q.push_back(8'($urandom_range(0, 127)));
            end else if (roll < 40) begin
                // characters that need escaping
                case ($urandom_range(0, 2))
                    0:       str_q.push_back(CH_QUOTE);
                    1:       str_q.push_back(CH_BSLASH);
                    default: str_q.push_back(8'($urandom_range(0, 31)));
                endcase
            end else if (roll < 55) begin
                cp = 21'($urandom_range(21'h80, 21'h7FF));
                str_q.push_back({3'b110, cp[10:6]});
                str_q.push_back({2'b10, cp[5:0]});
            end else if (roll < 68) begin
                cp = 21'($urandom_range(21'h800, 21'hFFFF));
                // step out of the surrogate range
                if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h1000;
                str_q.push_back({4'b1110, cp[15:12]});
                str_q.push_back({2'b10, cp[11:6]});
                str_q.push_back({2'b10, cp[5:0]});
            end else if (roll < 80) begin
                cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
                str_q.push_back({5'b11110, cp[20:18]});
                str_q.push_back({2'b10, cp[17:12]});
                str_q.push_back({2'b10, cp[11:6]});
                str_q.push_back({2'b10, cp[5:0]});
            end else if (roll < 90) begin
                // leads with a narrowed second byte, second byte near its limits
                case ($urandom_range(0, 3))
                    0:       b = 8'hE0;
                    1:       b = 8'hED;
                    2:       b = 8'hF0;
                    default: b = 8'hF4;
                endcase
                str_q.push_back(b);
                case ($urandom_range(0, 7))
                    0:       b = 8'h7F;
                    1:       b = 8'h80;
                    2:       b = 8'h8F;
                    3:       b = 8'h90;
                    4:       b = 8'h9F;
                    5:       b = 8'hA0;
                    6:       b = 8'hBF;
                    default: b = 8'hC0;
                endcase
                str_q.push_back(b);
                repeat ($urandom_range(0, 2))
                    str_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end else begin
                // junk: stray high bytes of any kind
                repeat ($urandom_range(1, 3)) str_q.push_back(8'($urandom_range(128, 255)));
            end
        end
    endtask

    task automatic build_binary();
        str_q.delete();
        repeat ($urandom_range(1, 7)) str_q.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int   roll;
        logic bin;
        logic keep_open;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 16'd0;
        s_tlast  <= 1'b0;
        s_tuser  <= 2'd0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // empty string with every other flag set, data must be ignored
        send_byte(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
        n_empty++;

        // text string: short escapes, hex escapes, pass-through, utf-8 cases
        send_byte(CH_QUOTE,  1'b1, 1'b0, 1'b0, 1'b0);
        send_byte(CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(CTL_BS,    1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(CTL_HT,    1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(CTL_LF,    1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(CTL_FF,    1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(CTL_CR,    1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h00,     1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h1F,     1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h7F,     1'b0, 1'b0, 1'b0, 1'b0);
        // valid four-byte sequence
        send_byte(8'hF0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h9F, 1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h98, 1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0, 1'b0, 1'b0);
        // plain ascii byte where a continuation byte belongs
        send_byte(8'hC3, 1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h41, 1'b0, 1'b0, 1'b0, 1'b0);
        // sequence cut short by the end of the string
        send_byte(8'hE2, 1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(8'h82, 1'b0, 1'b1, 1'b0, 1'b0);
        n_text++;

        // base64 string: one full group, one byte left for the padded tail
        send_byte(8'hFF, 1'b1, 1'b0, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
        send_byte(8'hFB, 1'b0, 1'b0, 1'b1, 1'b0);
        send_byte(8'h10, 1'b0, 1'b1, 1'b1, 1'b0);
        n_b64++;

        // byte with no string open stays in base64 mode and is only held,
        // then a new text string drops it; an invalid lead ends it
        send_byte(8'h3C, 1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(8'hC0, 1'b1, 1'b1, 1'b0, 1'b0);
        n_text++;

        drain_outputs();

        // random part: well formed strings with random content, some noise
        while (n_random < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
                n_empty++;
                n_random++;
            end else if (roll < 16) begin
                // lone request with arbitrary flags
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                n_random++;
            end else begin
                bin = (roll >= 62);
                if (bin) begin
                    build_binary();
                    n_b64++;
                end else begin
                    build_text();
                    n_text++;
                end
                // occasionally abandon the string so the next first byte drops it
                keep_open = ($urandom_range(0, 9) == 0);
                send_string(bin, keep_open);
                n_random += str_q.size();
            end
            if ($urandom_range(0, 15) == 0) drain_outputs();
        end

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d requests: %0d text strings, %0d base64 strings, %0d empty",
                 requests_seen, n_text, n_b64, n_empty);
        $display("%0d encoded bytes compared, %0d replacement characters, %0d mismatches",
                 bytes_checked, repl_count, mismatch_count);
        if (mismatch_count == 0 && bytes_owed == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
